// ===== design/atlb_pkg.sv =====
`default_nettype none

package atlb_pkg;

    // Sequencer steps of the tilt engine.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQZ,
        ST_PT,
        ST_PN,
        ST_PD_GO,
        ST_PD_WT,
        ST_RT,
        ST_RN,
        ST_RD_GO,
        ST_RD_WT,
        ST_MG_GO,
        ST_MG_WT,
        ST_XM,
        ST_XD_GO,
        ST_XD_WT,
        ST_YM,
        ST_YD_GO,
        ST_YD_WT,
        ST_BX,
        ST_BY,
        ST_BS_GO,
        ST_BS_WT,
        ST_CXM,
        ST_CXD_GO,
        ST_CXD_WT,
        ST_CYM,
        ST_CYD_GO,
        ST_CYD_WT,
        ST_FIN
    } atlb_state_t;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } atlb_op_t;

    typedef struct packed {
        logic     start;
        atlb_op_t op;
    } atlb_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } atlb_stat_t;

    // Operand widths of the shift-subtract unit.
    localparam int DVD_W = 50;
    localparam int DVS_W = 41;

    // Configuration register indexes.
    localparam logic [1:0] REG_RADIUS    = 2'd0;
    localparam logic [1:0] REG_LEVEL_TOL = 2'd1;
    localparam logic [1:0] REG_CENTER_X  = 2'd2;
    localparam logic [1:0] REG_CENTER_Y  = 2'd3;

    localparam logic [13:0] ATAN_K    = 14'd10314;
    localparam logic [18:0] G_COUNTS  = 19'd9812;
    localparam logic [19:0] MAG_FLOOR = 20'd500;
    localparam logic [12:0] ANG_90    = 13'd900;
    localparam logic [12:0] ANG_180   = 13'd1800;
    localparam logic [12:0] ANG_360   = 13'd3600;

endpackage

`default_nettype wire

// ===== design/accel_tilt_level_bubble.sv =====
// Tilt inclinometer with bubble-level position for a three-axis accelerometer.
// Input beats arrive on the s_ channel: three signed 19-bit axis readings in
// s_tdata and one valid flag per axis in s_tuser. Each input beat yields one
// output beat on the m_ channel carrying pitch and roll in decidegrees, the
// bubble center position and the level flag.
// Registers (radius, level tolerance, circle center) are written through the
// cfg_ port, one register per beat. Write them only while no sample is in
// flight; the block itself does not enforce this (cfg_ready is always high).
// The pace is set by the shared shift-subtract unit: four or six 50-step
// divisions (six when the bubble has to be pulled back onto the ring) and two
// 20-step square roots run one after another, with a single multiplier feeding
// it. s_tready is high only while the sequencer is idle, so one sample is in
// work at a time and a new sample is not taken before the last one is finished.
// The result sits in an output register; the next sample is taken while it
// waits. If the receiver stalls, a finished second result waits in the final
// step until the register frees up, and no new sample is taken meanwhile.
// Reset (aresetn low, synchronous) returns the sequencer to idle, drops
// m_tvalid and restores the register defaults: radius 78, tolerance 25,
// center (160, 96).
`default_nettype none

module accel_tilt_level_bubble (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // accel_x[18:0], accel_y[37:19], accel_z[56:38]
    input  wire logic [2:0]  s_tuser,   // x_valid[0], y_valid[1], z_valid[2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // pitch_deci[11:0], roll_deci[23:12],
                                        // bubble_x[34:24], bubble_y[45:35]
    output logic [0:0]       m_tuser,   // is_level[0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_data
);

    localparam int DW = atlb_pkg::DVD_W;
    localparam int SW = atlb_pkg::DVS_W;

    atlb_pkg::atlb_state_t state_reg, state_next;

    // Configuration registers.
    logic [7:0] radius_reg;
    logic [9:0] level_tol_reg;
    logic [8:0] center_x_reg, center_y_reg;

    // Sample magnitudes and signs. axp is set when x is positive, which makes
    // the pitch operand -x negative.
    logic [18:0] ax_m_reg, ay_m_reg, az_m_reg;
    logic        axp_reg, ayn_reg, azn_reg;

    // Working registers.
    logic [36:0]    sq_x_reg, sq_y_reg, sq_z_reg;
    logic [31:0]    t_reg;
    logic [DW-1:0]  num_reg;
    logic [11:0]    pitch_reg, roll_reg;
    logic [18:0]    mag_reg;
    logic [8:0]     dxm_reg, dym_reg, dbr_reg;
    logic           dx_neg_reg, dy_neg_reg;

    // Output register.
    logic           m_tvalid_reg;
    logic [47:0]    m_tdata_reg;
    logic           m_level_reg;

    // Shared multiplier.
    logic [31:0]    mul_a;
    logic [18:0]    mul_b;
    logic [50:0]    prod;

    // Shift-subtract unit.
    atlb_pkg::atlb_cmd_t  u_cmd;
    atlb_pkg::atlb_stat_t u_stat;
    logic [DW-1:0]        u_dvd;
    logic [SW-1:0]        u_dvs;
    logic [DW-1:0]        u_res;

    logic [18:0] ax_in, ay_in, az_in;
    logic        r8_neg, r9_neg;
    logic [7:0]  r8_mag, r9_mag;
    logic        pitch_big_x, roll_big_x;
    logic [SW-1:0] den_p, den_r;
    logic [39:0] mag_sum, bub_sum;
    logic        clamp_now;
    logic        out_free;
    logic [10:0] bx_val, by_val;
    logic [11:0] pitch_abs, roll_abs;

    function automatic logic [18:0] mag19(input logic [18:0] v);
        return v[18] ? (~v + 19'd1) : v;
    endfunction

    // 18*big + 5*small + 1
    function automatic logic [40:0] den_calc(input logic [36:0] big, input logic [36:0] small_sq);
        logic [40:0] b, s;
        b = {4'b0, big};
        s = {4'b0, small_sq};
        return (b << 4) + (b << 1) + (s << 2) + s + 41'd1;
    endfunction

    // Places the first-octant ratio into its quadrant and folds the angle to
    // the signed range; a result above 180 degrees wraps in two's complement.
    function automatic logic [11:0] fold_angle(input logic [8:0] q, input logic big_x,
                                              input logic x_neg, input logic y_neg);
        logic [12:0] base, a1, a2;
        base = big_x ? {4'b0, q} : atlb_pkg::ANG_90 - {4'b0, q};
        a1   = x_neg ? atlb_pkg::ANG_180 - base : base;
        a2   = y_neg ? atlb_pkg::ANG_360 - a1 : a1;
        if (a2 >= atlb_pkg::ANG_360) begin
            a2 = a2 - atlb_pkg::ANG_360;
        end
        if (a2 > atlb_pkg::ANG_180) begin
            a2 = a2 - atlb_pkg::ANG_360;
        end
        return a2[11:0];
    endfunction

    // Input decode: an invalid axis reads as zero, or as one g for z.
    always_comb begin
        ax_in = s_tuser[0] ? mag19(s_tdata[18:0]) : 19'd0;
        ay_in = s_tuser[1] ? mag19(s_tdata[37:19]) : 19'd0;
        az_in = s_tuser[2] ? mag19(s_tdata[56:38]) : atlb_pkg::G_COUNTS;
    end

    always_comb begin
        r8_neg = radius_reg < 8'd8;
        r9_neg = radius_reg < 8'd9;
        r8_mag = r8_neg ? 8'd8 - radius_reg : radius_reg - 8'd8;
        r9_mag = r9_neg ? 8'd9 - radius_reg : radius_reg - 8'd9;
        pitch_big_x = az_m_reg >= ax_m_reg;
        roll_big_x  = az_m_reg >= ay_m_reg;
        den_p = pitch_big_x ? den_calc(sq_z_reg, sq_x_reg) : den_calc(sq_x_reg, sq_z_reg);
        den_r = roll_big_x ? den_calc(sq_z_reg, sq_y_reg) : den_calc(sq_y_reg, sq_z_reg);
        mag_sum = {3'b0, sq_x_reg} + {3'b0, sq_y_reg} + {3'b0, sq_z_reg};
        bub_sum = {8'b0, t_reg} + num_reg[39:0];
        // The bubble leaves the ring when its length exceeds radius-9 and is
        // nonzero; a negative radius-9 catches every nonzero length.
        clamp_now = r9_neg ? (u_res[8:0] != 9'd0) : (u_res[8:0] > {1'b0, r9_mag});
        out_free  = !m_tvalid_reg || m_tready;
    end

    // Multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            atlb_pkg::ST_SQX: begin mul_a = {13'b0, ax_m_reg}; mul_b = ax_m_reg; end
            atlb_pkg::ST_SQY: begin mul_a = {13'b0, ay_m_reg}; mul_b = ay_m_reg; end
            atlb_pkg::ST_SQZ: begin mul_a = {13'b0, az_m_reg}; mul_b = az_m_reg; end
            atlb_pkg::ST_PT:  begin mul_a = {18'b0, atlb_pkg::ATAN_K}; mul_b = ax_m_reg; end
            atlb_pkg::ST_PN:  begin mul_a = t_reg; mul_b = az_m_reg; end
            atlb_pkg::ST_RT:  begin mul_a = {18'b0, atlb_pkg::ATAN_K}; mul_b = ay_m_reg; end
            atlb_pkg::ST_RN:  begin mul_a = t_reg; mul_b = az_m_reg; end
            atlb_pkg::ST_XM:  begin mul_a = {13'b0, ax_m_reg}; mul_b = {11'b0, r8_mag}; end
            atlb_pkg::ST_YM:  begin mul_a = {13'b0, ay_m_reg}; mul_b = {11'b0, r8_mag}; end
            atlb_pkg::ST_BX:  begin mul_a = {23'b0, dxm_reg}; mul_b = {10'b0, dxm_reg}; end
            atlb_pkg::ST_BY:  begin mul_a = {23'b0, dym_reg}; mul_b = {10'b0, dym_reg}; end
            atlb_pkg::ST_CXM: begin mul_a = {23'b0, dxm_reg}; mul_b = {11'b0, r9_mag}; end
            atlb_pkg::ST_CYM: begin mul_a = {23'b0, dym_reg}; mul_b = {11'b0, r9_mag}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        prod = {19'b0, mul_a} * {32'b0, mul_b};
    end

    // Commands to the shift-subtract unit.
    always_comb begin
        u_cmd.start = 1'b0;
        u_cmd.op    = atlb_pkg::OP_DIV;
        u_dvd       = num_reg;
        u_dvs       = '0;
        case (state_reg)
            atlb_pkg::ST_PD_GO: begin
                u_cmd.start = 1'b1;
                u_dvs       = den_p;
            end
            atlb_pkg::ST_RD_GO: begin
                u_cmd.start = 1'b1;
                u_dvs       = den_r;
            end
            atlb_pkg::ST_MG_GO: begin
                u_cmd.start = 1'b1;
                u_cmd.op    = atlb_pkg::OP_SQRT;
                u_dvd       = {10'b0, mag_sum};
            end
            atlb_pkg::ST_XD_GO, atlb_pkg::ST_YD_GO: begin
                u_cmd.start = 1'b1;
                u_dvs       = {22'b0, mag_reg};
            end
            atlb_pkg::ST_BS_GO: begin
                u_cmd.start = 1'b1;
                u_cmd.op    = atlb_pkg::OP_SQRT;
                u_dvd       = {10'b0, bub_sum};
            end
            atlb_pkg::ST_CXD_GO, atlb_pkg::ST_CYD_GO: begin
                u_cmd.start = 1'b1;
                u_dvs       = {32'b0, dbr_reg};
            end
            default: begin
                u_cmd.start = 1'b0;
            end
        endcase
    end

    atlb_shsub u_shsub (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (u_cmd),
        .dividend (u_dvd),
        .divisor  (u_dvs),
        .status   (u_stat),
        .result   (u_res)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            atlb_pkg::ST_IDLE:   if (s_tvalid) state_next = atlb_pkg::ST_SQX;
            atlb_pkg::ST_SQX:    state_next = atlb_pkg::ST_SQY;
            atlb_pkg::ST_SQY:    state_next = atlb_pkg::ST_SQZ;
            atlb_pkg::ST_SQZ:    state_next = atlb_pkg::ST_PT;
            atlb_pkg::ST_PT:     state_next = atlb_pkg::ST_PN;
            atlb_pkg::ST_PN:     state_next = atlb_pkg::ST_PD_GO;
            atlb_pkg::ST_PD_GO:  state_next = atlb_pkg::ST_PD_WT;
            atlb_pkg::ST_PD_WT:  if (u_stat.done) state_next = atlb_pkg::ST_RT;
            atlb_pkg::ST_RT:     state_next = atlb_pkg::ST_RN;
            atlb_pkg::ST_RN:     state_next = atlb_pkg::ST_RD_GO;
            atlb_pkg::ST_RD_GO:  state_next = atlb_pkg::ST_RD_WT;
            atlb_pkg::ST_RD_WT:  if (u_stat.done) state_next = atlb_pkg::ST_MG_GO;
            atlb_pkg::ST_MG_GO:  state_next = atlb_pkg::ST_MG_WT;
            atlb_pkg::ST_MG_WT:  if (u_stat.done) state_next = atlb_pkg::ST_XM;
            atlb_pkg::ST_XM:     state_next = atlb_pkg::ST_XD_GO;
            atlb_pkg::ST_XD_GO:  state_next = atlb_pkg::ST_XD_WT;
            atlb_pkg::ST_XD_WT:  if (u_stat.done) state_next = atlb_pkg::ST_YM;
            atlb_pkg::ST_YM:     state_next = atlb_pkg::ST_YD_GO;
            atlb_pkg::ST_YD_GO:  state_next = atlb_pkg::ST_YD_WT;
            atlb_pkg::ST_YD_WT:  if (u_stat.done) state_next = atlb_pkg::ST_BX;
            atlb_pkg::ST_BX:     state_next = atlb_pkg::ST_BY;
            atlb_pkg::ST_BY:     state_next = atlb_pkg::ST_BS_GO;
            atlb_pkg::ST_BS_GO:  state_next = atlb_pkg::ST_BS_WT;
            atlb_pkg::ST_BS_WT: begin
                if (u_stat.done) begin
                    state_next = clamp_now ? atlb_pkg::ST_CXM : atlb_pkg::ST_FIN;
                end
            end
            atlb_pkg::ST_CXM:    state_next = atlb_pkg::ST_CXD_GO;
            atlb_pkg::ST_CXD_GO: state_next = atlb_pkg::ST_CXD_WT;
            atlb_pkg::ST_CXD_WT: if (u_stat.done) state_next = atlb_pkg::ST_CYM;
            atlb_pkg::ST_CYM:    state_next = atlb_pkg::ST_CYD_GO;
            atlb_pkg::ST_CYD_GO: state_next = atlb_pkg::ST_CYD_WT;
            atlb_pkg::ST_CYD_WT: if (u_stat.done) state_next = atlb_pkg::ST_FIN;
            atlb_pkg::ST_FIN:    if (out_free) state_next = atlb_pkg::ST_IDLE;
            default:             state_next = atlb_pkg::ST_IDLE;
        endcase
    end

    // Result assembly for the output register.
    always_comb begin
        bx_val = {2'b0, center_x_reg} + (dx_neg_reg ? -{2'b0, dxm_reg} : {2'b0, dxm_reg});
        by_val = {2'b0, center_y_reg} + (dy_neg_reg ? -{2'b0, dym_reg} : {2'b0, dym_reg});
        pitch_abs = pitch_reg[11] ? -pitch_reg : pitch_reg;
        roll_abs  = roll_reg[11] ? -roll_reg : roll_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= atlb_pkg::ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            radius_reg    <= 8'd78;
            level_tol_reg <= 10'd25;
            center_x_reg  <= 9'd160;
            center_y_reg  <= 9'd96;
        end else begin
            state_reg <= state_next;
            if (state_reg == atlb_pkg::ST_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    atlb_pkg::REG_RADIUS:    radius_reg    <= cfg_data[7:0];
                    atlb_pkg::REG_LEVEL_TOL: level_tol_reg <= cfg_data;
                    atlb_pkg::REG_CENTER_X:  center_x_reg  <= cfg_data[8:0];
                    atlb_pkg::REG_CENTER_Y:  center_y_reg  <= cfg_data[8:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers, loaded step by step.
    always_ff @(posedge aclk) begin
        case (state_reg)
            atlb_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    ax_m_reg <= ax_in;
                    ay_m_reg <= ay_in;
                    az_m_reg <= az_in;
                    axp_reg  <= s_tuser[0] && !s_tdata[18] && (s_tdata[17:0] != 18'd0);
                    ayn_reg  <= s_tuser[1] && s_tdata[37];
                    azn_reg  <= s_tuser[2] && s_tdata[56];
                end
            end
            atlb_pkg::ST_SQX: sq_x_reg <= prod[36:0];
            atlb_pkg::ST_SQY: sq_y_reg <= prod[36:0];
            atlb_pkg::ST_SQZ: sq_z_reg <= prod[36:0];
            atlb_pkg::ST_PT, atlb_pkg::ST_RT, atlb_pkg::ST_BX: t_reg <= prod[31:0];
            atlb_pkg::ST_PN, atlb_pkg::ST_RN, atlb_pkg::ST_XM, atlb_pkg::ST_YM,
            atlb_pkg::ST_BY, atlb_pkg::ST_CXM, atlb_pkg::ST_CYM: num_reg <= prod[DW-1:0];
            atlb_pkg::ST_PD_WT: begin
                if (u_stat.done) begin
                    pitch_reg <= fold_angle(u_res[8:0], pitch_big_x, azn_reg, axp_reg);
                end
            end
            atlb_pkg::ST_RD_WT: begin
                if (u_stat.done) begin
                    roll_reg <= fold_angle(u_res[8:0], roll_big_x, azn_reg, ayn_reg);
                end
            end
            atlb_pkg::ST_MG_WT: begin
                // A near-zero magnitude stands in as one g.
                if (u_stat.done) begin
                    mag_reg <= (u_res[19:0] < atlb_pkg::MAG_FLOOR) ? atlb_pkg::G_COUNTS
                                                                   : u_res[18:0];
                end
            end
            atlb_pkg::ST_XD_WT: begin
                if (u_stat.done) begin
                    dxm_reg    <= u_res[8:0];
                    dx_neg_reg <= axp_reg ^ r8_neg;
                end
            end
            atlb_pkg::ST_YD_WT: begin
                if (u_stat.done) begin
                    dym_reg    <= u_res[8:0];
                    dy_neg_reg <= ayn_reg ^ r8_neg;
                end
            end
            atlb_pkg::ST_BS_WT: if (u_stat.done) dbr_reg <= u_res[8:0];
            atlb_pkg::ST_CXD_WT: begin
                if (u_stat.done) begin
                    dxm_reg    <= u_res[8:0];
                    dx_neg_reg <= dx_neg_reg ^ r9_neg;
                end
            end
            atlb_pkg::ST_CYD_WT: begin
                if (u_stat.done) begin
                    dym_reg    <= u_res[8:0];
                    dy_neg_reg <= dy_neg_reg ^ r9_neg;
                end
            end
            atlb_pkg::ST_FIN: begin
                if (out_free) begin
                    m_tdata_reg <= {2'b0, by_val, bx_val, roll_reg, pitch_reg};
                    m_level_reg <= (pitch_abs < {2'b0, level_tol_reg}) &&
                                   (roll_abs < {2'b0, level_tol_reg});
                end
            end
            default: ;
        endcase
    end

    assign s_tready   = (state_reg == atlb_pkg::ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_level_reg;

    // An accepted sample always starts the sequence with the squares.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == atlb_pkg::ST_SQX))
        else $error("sample accepted without starting the sequence");

    // The shared unit is never restarted while it is still iterating.
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        u_cmd.start |-> !u_stat.busy)
        else $error("shift-subtract unit restarted while busy");

    // A finished operation is only reported while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        u_stat.done |-> (state_reg == atlb_pkg::ST_PD_WT || state_reg == atlb_pkg::ST_RD_WT ||
                         state_reg == atlb_pkg::ST_MG_WT || state_reg == atlb_pkg::ST_XD_WT ||
                         state_reg == atlb_pkg::ST_YD_WT || state_reg == atlb_pkg::ST_BS_WT ||
                         state_reg == atlb_pkg::ST_CXD_WT || state_reg == atlb_pkg::ST_CYD_WT))
        else $error("unit finished outside a wait step");

    // Delivered pitch stays inside the folded range.
    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[11:0]) >= -12'sd1799 &&
                      $signed(m_tdata[11:0]) <= 12'sd1800))
        else $error("pitch outside folded range");

endmodule

`default_nettype wire

// ===== design/atlb_shsub.sv =====
`default_nettype none

// Iterative shift-subtract unit: restoring division (one quotient bit per cycle)
// or floor square root (one root bit per cycle), sharing a single subtractor.
module atlb_shsub (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire atlb_pkg::atlb_cmd_t           cmd,
    input  wire logic [atlb_pkg::DVD_W-1:0]    dividend,
    input  wire logic [atlb_pkg::DVS_W-1:0]    divisor,
    output atlb_pkg::atlb_stat_t               status,
    output logic      [atlb_pkg::DVD_W-1:0]    result
);

    localparam int DW = atlb_pkg::DVD_W;
    localparam int SW = atlb_pkg::DVS_W;
    localparam int RW = 20;
    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] DIV_LAST  = CW'(DW - 1);
    localparam logic [CW-1:0] SQRT_LAST = CW'(RW - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    atlb_pkg::atlb_op_t  op_reg;
    logic [CW-1:0]       cnt_reg;
    logic [SW-1:0]       rem_reg, dsr_reg;
    logic [DW-1:0]       q_reg;
    logic [RW-1:0]       root_reg;

    logic [SW:0]         sh;
    logic [SW:0]         subt;
    logic [SW+1:0]       diff;
    logic                ge;

    always_comb begin
        if (op_reg == atlb_pkg::OP_DIV) begin
            sh   = {rem_reg, q_reg[DW-1]};
            subt = {1'b0, dsr_reg};
        end else begin
            sh   = {rem_reg[SW-2:0], q_reg[DW-1:DW-2]};
            subt = {(SW-RW-1)'(0), root_reg, 2'b01};
        end
        diff = {1'b0, sh} - {1'b0, subt};
        ge   = !diff[SW+1];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            busy_next = 1'b1;
        end else if (busy_reg && cnt_reg == '0) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg   <= cmd.op;
            rem_reg  <= '0;
            root_reg <= '0;
            dsr_reg  <= divisor;
            if (cmd.op == atlb_pkg::OP_DIV) begin
                cnt_reg <= DIV_LAST;
                q_reg   <= dividend;
            end else begin
                cnt_reg <= SQRT_LAST;
                q_reg   <= {dividend[2*RW-1:0], (DW-2*RW)'(0)};
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            rem_reg <= ge ? diff[SW-1:0] : sh[SW-1:0];
            if (op_reg == atlb_pkg::OP_DIV) begin
                q_reg <= {q_reg[DW-2:0], ge};
            end else begin
                q_reg    <= {q_reg[DW-3:0], 2'b00};
                root_reg <= {root_reg[RW-2:0], ge};
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign result = (op_reg == atlb_pkg::OP_DIV) ? q_reg : {(DW-RW)'(0), root_reg};

endmodule

`default_nettype wire

// ===== verif/accel_tilt_level_bubble_tb.sv =====
`default_nettype none

module accel_tilt_level_bubble_tb;

    // One accelerometer sample as it travels on the input channel.
    typedef struct {
        logic signed [18:0] ax;
        logic signed [18:0] ay;
        logic signed [18:0] az;
        logic [2:0]         vld;   // x, y, z valid flags, lowest bit first
    } sample_t;

    // One tilt result as it travels on the output channel.
    typedef struct {
        logic signed [11:0] pitch;
        logic signed [11:0] roll;
        logic               level;
        logic signed [10:0] bx;
        logic signed [10:0] by;
    } tilt_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // accel_x[18:0], accel_y[37:19], accel_z[56:38]
    logic [2:0]  s_tuser;    // x_valid[0], y_valid[1], z_valid[2]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // pitch[11:0], roll[23:12], bubble_x[34:24], bubble_y[45:35]
    logic [0:0]  m_tuser;    // is_level[0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [9:0]  cfg_data;

    accel_tilt_level_bubble u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // The testbench keeps its own copy of the four registers.
    longint  radius_q, tol_q, cen_x_q, cen_y_q;

    sample_t pending_samples[$];
    tilt_t   expected_tilts[$];
    int      errors;
    int      samples_sent;
    int      tilts_seen;
    int      idle_cycles;
    int      send_gap;
    int      recv_gap;
    bit      timed_out;
    bit      stim_done;

    // Integer square root, rounded down, by bit pairs.
    function automatic longint isqrt(longint n);
        longint root;
        longint b;
        root = 0;
        b = longint'(1) << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // Rational atan2 of (num, den), in decidegrees counter-clockwise, folded to -1799..1800.
    function automatic longint atan_dd(longint num, longint den);
        longint an, ad, ang;
        if (num == 0 && den == 0) return 0;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        if (ad >= an)
            ang = (10314 * an * ad) / (18 * ad * ad + 5 * an * an + 1);
        else
            ang = 900 - (10314 * ad * an) / (18 * an * an + 5 * ad * ad + 1);
        if (den < 0) ang = 1800 - ang;
        if (num < 0) ang = 3600 - ang;
        if (ang >= 3600) ang = ang - 3600;
        return (ang > 1800) ? ang - 3600 : ang;
    endfunction

    // Works out pitch, roll, level flag and bubble position of one sample.
    function automatic tilt_t tilt_of(sample_t s);
        tilt_t  t;
        longint x, y, z, p, r, mag, dx, dy, dlen, lim, bx, by;
        x = s.vld[0] ? longint'(s.ax) : 0;
        y = s.vld[1] ? longint'(s.ay) : 0;
        z = s.vld[2] ? longint'(s.az) : 9812;
        p = atan_dd(-x, z);
        r = atan_dd(y, z);
        mag = isqrt(x * x + y * y + z * z);
        if (mag < 500) mag = 9812;
        dx = (-x * (radius_q - 8)) / mag;
        dy = (y * (radius_q - 8)) / mag;
        dlen = isqrt(dx * dx + dy * dy);
        lim = radius_q - 9;
        // Pull the bubble back onto the ring when it lies outside it.
        if (dlen > lim && dlen > 0) begin
            dx = (dx * lim) / dlen;
            dy = (dy * lim) / dlen;
        end
        bx = cen_x_q + dx;
        by = cen_y_q + dy;
        t.pitch = p[11:0];
        t.roll  = r[11:0];
        t.level = ((p < 0 ? -p : p) < tol_q) && ((r < 0 ? -r : r) < tol_q);
        t.bx    = bx[10:0];
        t.by    = by[10:0];
        return t;
    endfunction

    function automatic sample_t mk(longint x, longint y, longint z, logic [2:0] v);
        sample_t s;
        s.ax = x[18:0];
        s.ay = y[18:0];
        s.az = z[18:0];
        s.vld = v;
        return s;
    endfunction

    // An axis value: mostly within +-12000, sometimes within +-600 or +-20, sometimes anything in range.
    function automatic longint rand_axis();
        case ($urandom_range(0, 5))
            0: return longint'($urandom_range(0, 524287)) - 262144;
            1: return longint'($urandom_range(0, 40)) - 20;
            2: return longint'($urandom_range(0, 1200)) - 600;
            default: return longint'($urandom_range(0, 24000)) - 12000;
        endcase
    endfunction

    // Input driver: one beat per pending sample, with a random gap before each.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= $urandom_range(0, 14);
        end else if (s_tvalid && s_tready) begin
            samples_sent <= samples_sent + 1;
            expected_tilts.push_back(tilt_of(pending_samples.pop_front()));
            s_tvalid <= 1'b0;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        end else if (!s_tvalid && pending_samples.size() != 0) begin
            if (send_gap == 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, pending_samples[0].az, pending_samples[0].ay,
                             pending_samples[0].ax};
                s_tuser  <= pending_samples[0].vld;
            end else begin
                send_gap <= send_gap - 1;
            end
        end
    end

    // Output monitor: checks each result beat and stalls the receiver at random.
    always @(posedge aclk) begin
        tilt_t want, got;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                tilts_seen <= tilts_seen + 1;
                got.pitch = m_tdata[11:0];
                got.roll  = m_tdata[23:12];
                got.bx    = m_tdata[34:24];
                got.by    = m_tdata[45:35];
                got.level = m_tuser[0];
                if (expected_tilts.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %h/%b", $realtime,
                             m_tdata, m_tuser);
                    errors = errors + 1;
                end else begin
                    want = expected_tilts.pop_front();
                    if (got.pitch !== want.pitch) begin
                        $display("%0t: pitch expected %0d actual %0d", $realtime,
                                 want.pitch, got.pitch);
                        errors = errors + 1;
                    end
                    if (got.roll !== want.roll) begin
                        $display("%0t: roll expected %0d actual %0d", $realtime,
                                 want.roll, got.roll);
                        errors = errors + 1;
                    end
                    if (got.level !== want.level) begin
                        $display("%0t: level expected %0b actual %0b", $realtime,
                                 want.level, got.level);
                        errors = errors + 1;
                    end
                    if (got.bx !== want.bx) begin
                        $display("%0t: bubble_x expected %0d actual %0d", $realtime,
                                 want.bx, got.bx);
                        errors = errors + 1;
                    end
                    if (got.by !== want.by) begin
                        $display("%0t: bubble_y expected %0d actual %0d", $realtime,
                                 want.by, got.by);
                        errors = errors + 1;
                    end
                end
            end
            // Stall for a drawn number of cycles between beats, ready otherwise.
            if (m_tvalid && m_tready) begin
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                m_tready <= 1'b0;
            end else if (recv_gap == 0) begin
                m_tready <= 1'b1;
            end else begin
                recv_gap <= recv_gap - 1;
            end
        end
    end

    // Watchdog: counts cycles in which no beat moves on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1'b1;
            end
        end
    end

    // Writes one register through the configuration channel and mirrors it.
    task automatic write_reg(logic [1:0] idx, logic [9:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            atlb_pkg::REG_RADIUS:    radius_q = val[7:0];
            atlb_pkg::REG_LEVEL_TOL: tol_q    = val;
            atlb_pkg::REG_CENTER_X:  cen_x_q  = val[8:0];
            atlb_pkg::REG_CENTER_Y:  cen_y_q  = val[8:0];
            default: ;
        endcase
    endtask

    // Waits until every queued sample is sent and every result has arrived.
    task automatic drain();
        while (pending_samples.size() != 0 || s_tvalid || expected_tilts.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) begin
            logic [2:0] v;
            v = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'b111;
            pending_samples.push_back(mk(rand_axis(), rand_axis(), rand_axis(), v));
        end
    endtask

    // Directed samples: field extremes, invalid axes, zero operands, tiny
    // magnitudes and bubbles far outside the ring.
    task automatic queue_directed();
        pending_samples.push_back(mk(0, 0, 9812, 3'b111));
        pending_samples.push_back(mk(0, 0, 0, 3'b111));
        pending_samples.push_back(mk(0, 0, 0, 3'b000));
        pending_samples.push_back(mk(262143, 262143, 262143, 3'b111));
        pending_samples.push_back(mk(-262144, -262144, -262144, 3'b111));
        pending_samples.push_back(mk(-262144, 262143, 0, 3'b111));
        pending_samples.push_back(mk(262143, -262144, -1, 3'b111));
        pending_samples.push_back(mk(123, -456, 789, 3'b000));
        pending_samples.push_back(mk(5000, 5000, -9812, 3'b011));
        pending_samples.push_back(mk(-9812, 0, 0, 3'b101));
        pending_samples.push_back(mk(0, 9812, 0, 3'b110));
        pending_samples.push_back(mk(0, 0, -9812, 3'b111));
        pending_samples.push_back(mk(100, 200, 300, 3'b111));
        pending_samples.push_back(mk(-100, -200, 0, 3'b111));
        pending_samples.push_back(mk(20, -20, 9812, 3'b111));
        pending_samples.push_back(mk(-5, 4, 9800, 3'b111));
        pending_samples.push_back(mk(9812, 9812, 1, 3'b111));
        pending_samples.push_back(mk(1, 0, 0, 3'b111));
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = atlb_pkg::REG_RADIUS;
        cfg_data  = '0;
        errors = 0;
        samples_sent = 0;
        tilts_seen = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        stim_done = 1'b0;
        radius_q = 78;
        tol_q = 25;
        cen_x_q = 160;
        cen_y_q = 96;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults first, then a range of settings including extremes
        // and a radius small enough to mirror the bubble.
        queue_directed();
        queue_random(150);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(atlb_pkg::REG_RADIUS, 10'd200);
                    write_reg(atlb_pkg::REG_LEVEL_TOL, 10'd900);
                    write_reg(atlb_pkg::REG_CENTER_X, 10'd511);
                    write_reg(atlb_pkg::REG_CENTER_Y, 10'd511);
                end
                1: begin
                    write_reg(atlb_pkg::REG_RADIUS, 10'd16);
                    write_reg(atlb_pkg::REG_LEVEL_TOL, 10'd0);
                    write_reg(atlb_pkg::REG_CENTER_X, 10'd0);
                    write_reg(atlb_pkg::REG_CENTER_Y, 10'd0);
                end
                2: begin
                    write_reg(atlb_pkg::REG_RADIUS, 10'd3);
                    write_reg(atlb_pkg::REG_LEVEL_TOL, 10'd1023);
                    write_reg(atlb_pkg::REG_CENTER_X, 10'd5);
                    write_reg(atlb_pkg::REG_CENTER_Y, 10'd300);
                end
                3: begin
                    write_reg(atlb_pkg::REG_RADIUS, 10'd255);
                    write_reg(atlb_pkg::REG_LEVEL_TOL, 10'd1);
                end
                4: begin
                    write_reg(atlb_pkg::REG_RADIUS, 10'd0);
                    write_reg(atlb_pkg::REG_CENTER_X, 10'd200);
                end
                default: begin
                    write_reg(atlb_pkg::REG_RADIUS, 10'($urandom_range(16, 200)));
                    write_reg(atlb_pkg::REG_LEVEL_TOL, 10'($urandom_range(0, 900)));
                    write_reg(atlb_pkg::REG_CENTER_X, 10'($urandom_range(0, 511)));
                    write_reg(atlb_pkg::REG_CENTER_Y, 10'($urandom_range(0, 511)));
                end
            endcase
            queue_directed();
            queue_random(120);
            drain();
        end
        stim_done = 1'b1;
    end

    // Ends the run once all samples are checked or the watchdog fires.
    initial begin
        wait (aresetn === 1'b1);
        while (!timed_out && !stim_done)
            @(posedge aclk);
        repeat (600) @(posedge aclk);
        $display("Run covered %0d samples over seven register settings, %0d results checked.",
                 samples_sent, tilts_seen);
        if (timed_out) begin
            $display("Watchdog expired with %0d results outstanding.",
                     expected_tilts.size());
            $display("Verification failed");
        end else if (errors == 0 && expected_tilts.size() == 0 &&
                     tilts_seen == samples_sent) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
